// ===== sv/potb_pkg.sv =====
// Shared types and constants for the periodic/one-shot timer bank.
package potb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int TICK_BITS  = 16;

  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_ENABLE    = 4'd1,
    OP_DISABLE   = 4'd2,
    OP_ONESHOT   = 4'd3,
    OP_RELOAD    = 4'd4,
    OP_OVERFLOW  = 4'd5,
    OP_REMAINING = 4'd6,
    OP_TARGET    = 4'd7,
    OP_FAULT     = 4'd8,
    OP_CONSUMED  = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    KIND_ACK      = 3'd0,
    KIND_SIGNAL   = 3'd1,
    KIND_FATAL    = 3'd2,
    KIND_TICK_OVF = 3'd3,
    KIND_BAD_ID   = 3'd4,
    KIND_EMPTY    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OVF,
    ST_SCAN,
    ST_FIRE,
    ST_EMIT,
    ST_WAIT
  } state_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  which_timer;
    logic [7:0]  dest_task;
    logic [7:0]  sent_signals;
    logic [7:0]  error_code;
    logic [15:0] reply_value;
    logic        last;
  } result_t;

endpackage

// ===== sv/periodic_oneshot_timer_bank.sv =====
// Top level of the timer bank: sequencer, timer state and output register.
//
// Channel | Dir | tdata fields (low bit up)                              | tuser | tlast
// in_     | in  | op, timer_index, pending_ticks, tick_value,            | -     | -
//         |     | target_task, target_signals, fault_code (64 bits)      |       |
// out_    | out | kind, which_timer, dest_task, sent_signals,            | -     | last
//         |     | error_code, reply_value (56 bits)                      |       |
//
// With out_tready high, a configure or query op goes through decode, emit (or fire) and
// wait, an unknown op or a bad index through decode and wait, and a tick with nothing
// pending from decode back to idle. A tick scans the timers: one shared compare/add unit
// checks one timer a cycle while no result waits; each fired timer goes through fire and
// wait, and the scan stops after the last match. A tick overflow result goes out first.
// rst_n is synchronous; it clears the counter, all flags and all timer words.
// in_tready is high only in the idle state; every result waits for out_tready.
module periodic_oneshot_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // op[3:0] idx[11:4] pend[19:12] tval[35:20]
                                  // task[43:36] sigs[51:44] fault[59:52]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // kind[2:0] which[10:3] task[18:11] sigs[26:19]
                                  // err[34:27] reply[50:35]
  output logic        out_tlast
);

  localparam int N = potb_pkg::NUM_TIMERS;

  potb_pkg::state_t state_r, state_nxt;

  logic [3:0]  op_r;
  logic [7:0]  idx_r;
  logic [7:0]  pend_r;
  logic [15:0] tval_r;
  logic [7:0]  task_in_r;
  logic [7:0]  sigs_in_r;
  logic [7:0]  fault_in_r;

  logic [potb_pkg::TICK_BITS-1:0] tick_count_r;
  logic [N-1:0]  armed_r, overrun_r, outst_r;
  logic [15:0]   expiry_r [N];
  logic [15:0]   reload_r [N];
  logic [7:0]    tfault_r [N];
  logic [7:0]    ttask_r  [N];
  logic [7:0]    tsigs_r  [N];

  logic [potb_pkg::IDX_W-1:0] scan_r, scan_nxt;
  logic                      oneshot_r; // clear reload after firing

  potb_pkg::result_t res_r, res_nxt;
  logic              res_valid_r, res_valid_nxt;

  // Shared adder: expiry or now plus reload, and the remaining-time subtract.
  logic [potb_pkg::IDX_W-1:0] sel;
  logic [15:0] now16, add_a, add_b, add_y;
  logic        sub_mode;
  logic        idx_ok;
  logic        is_last_scan;
  logic        hit;

  assign now16  = 16'(tick_count_r);
  assign idx_ok = (idx_r < 8'(N));
  assign sel    = (state_r == potb_pkg::ST_SCAN || state_r == potb_pkg::ST_FIRE) &&
                  (op_r == potb_pkg::OP_TICK) ? scan_r : idx_r[potb_pkg::IDX_W-1:0];
  assign add_b  = sub_mode ? ~now16 : reload_r[sel];
  assign add_y  = add_a + add_b + {15'd0, sub_mode};
  assign hit    = armed_r[sel] && (expiry_r[sel] == now16);
  assign is_last_scan = (scan_r == potb_pkg::IDX_W'(N - 1));

  always_comb begin
    sub_mode = (op_r == potb_pkg::OP_REMAINING);
    if (sub_mode) begin
      add_a = expiry_r[sel];
    end else if (op_r == potb_pkg::OP_TICK) begin
      add_a = expiry_r[sel];
    end else begin
      add_a = now16;
    end
  end

  assign in_tready  = (state_r == potb_pkg::ST_IDLE);
  assign out_tvalid = res_valid_r;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {5'd0, res_r.reply_value, res_r.error_code, res_r.sent_signals,
                       res_r.dest_task, res_r.which_timer, res_r.kind};

  // Armed match after a timer; incl also takes the timer itself.
  function automatic logic later_hit(input logic [potb_pkg::IDX_W-1:0] from,
                                     input logic incl,
                                     input logic [N-1:0] arm,
                                     input logic [15:0] t,
                                     input logic [15:0] ex [N]);
    logic r;
    r = 1'b0;
    for (int k = 0; k < N; k++) begin
      if ((k > int'(from) || (incl && k == int'(from))) && arm[k] && ex[k] == t) r = 1'b1;
    end
    return r;
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      potb_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = potb_pkg::ST_DECODE;
      end
      potb_pkg::ST_DECODE: begin
        if (op_r == potb_pkg::OP_TICK) begin
          if (pend_r == 8'd0) state_nxt = potb_pkg::ST_IDLE;
          else if (pend_r > 8'd1) state_nxt = potb_pkg::ST_OVF;
          else state_nxt = potb_pkg::ST_SCAN;
        end else if (op_r > potb_pkg::OP_CONSUMED || !idx_ok) begin
          state_nxt = potb_pkg::ST_WAIT;
        end else if ((op_r == potb_pkg::OP_ENABLE || op_r == potb_pkg::OP_ONESHOT) &&
                     ((op_r == potb_pkg::OP_ONESHOT) ? (tval_r == 16'd0)
                                                     : (reload_r[sel] == 16'd0))) begin
          state_nxt = potb_pkg::ST_FIRE;
        end else begin
          state_nxt = potb_pkg::ST_EMIT;
        end
      end
      potb_pkg::ST_OVF: state_nxt = potb_pkg::ST_WAIT;
      potb_pkg::ST_SCAN: begin
        if (hit) state_nxt = potb_pkg::ST_FIRE;
        else if (is_last_scan) state_nxt = potb_pkg::ST_IDLE;
      end
      potb_pkg::ST_FIRE: state_nxt = potb_pkg::ST_WAIT;
      potb_pkg::ST_EMIT: state_nxt = potb_pkg::ST_WAIT;
      potb_pkg::ST_WAIT: begin
        // A tick goes on scanning until its final result has left.
        if (out_tready) begin
          if (op_r == potb_pkg::OP_TICK && !res_r.last) state_nxt = potb_pkg::ST_SCAN;
          else state_nxt = potb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = potb_pkg::ST_IDLE;
    endcase
  end

  // Result register, its valid flag and the scan pointer.
  always_comb begin
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !out_tready;
    scan_nxt      = scan_r;
    case (state_r)
      potb_pkg::ST_IDLE: begin
        if (in_tvalid) scan_nxt = '0;
      end
      potb_pkg::ST_DECODE: begin
        res_nxt = '0;
        if (op_r != potb_pkg::OP_TICK) begin
          if (op_r > potb_pkg::OP_CONSUMED) begin
            res_nxt.kind  = potb_pkg::KIND_ACK;
            res_nxt.last  = 1'b1;
            res_valid_nxt = 1'b1;
          end else if (!idx_ok) begin
            res_nxt.kind        = potb_pkg::KIND_BAD_ID;
            res_nxt.which_timer = idx_r;
            res_nxt.last        = 1'b1;
            res_valid_nxt       = 1'b1;
          end
        end
      end
      potb_pkg::ST_OVF: begin
        // The counter has advanced; last when no timer matches the new time.
        res_nxt       = '0;
        res_nxt.kind  = potb_pkg::KIND_TICK_OVF;
        res_nxt.last  = !later_hit(scan_r, 1'b1, armed_r, now16, expiry_r);
        res_valid_nxt = 1'b1;
      end
      potb_pkg::ST_SCAN: begin
        if (!hit && !is_last_scan) scan_nxt = scan_r + 1'b1;
      end
      potb_pkg::ST_FIRE: begin
        res_nxt = '0;
        res_nxt.which_timer = 8'(sel);
        if (tfault_r[sel] != 8'd0) begin
          res_nxt.kind       = potb_pkg::KIND_FATAL;
          res_nxt.error_code = tfault_r[sel];
        end else begin
          res_nxt.kind         = potb_pkg::KIND_SIGNAL;
          res_nxt.dest_task    = ttask_r[sel];
          res_nxt.sent_signals = tsigs_r[sel];
        end
        res_nxt.last = (op_r != potb_pkg::OP_TICK) || is_last_scan ||
                       !later_hit(scan_r, 1'b0, armed_r, now16, expiry_r);
        res_valid_nxt = 1'b1;
        if (op_r == potb_pkg::OP_TICK && !is_last_scan) scan_nxt = scan_r + 1'b1;
      end
      potb_pkg::ST_EMIT: begin
        res_nxt = '0;
        res_nxt.kind        = potb_pkg::KIND_ACK;
        res_nxt.which_timer = idx_r;
        case (op_r)
          potb_pkg::OP_OVERFLOW:  res_nxt.reply_value = {15'd0, overrun_r[sel]};
          potb_pkg::OP_REMAINING: res_nxt.reply_value = armed_r[sel] ? add_y : 16'd0;
          potb_pkg::OP_TARGET: begin
            if (sigs_in_r == 8'd0) res_nxt.kind = potb_pkg::KIND_EMPTY;
          end
          default: ;
        endcase
        res_nxt.last  = 1'b1;
        res_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer registers and timer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= potb_pkg::ST_IDLE;
      tick_count_r <= '0;
      armed_r      <= '0;
      overrun_r    <= '0;
      outst_r      <= '0;
      res_r        <= '0;
      res_valid_r  <= 1'b0;
      scan_r       <= '0;
      oneshot_r    <= 1'b0;
      for (int k = 0; k < N; k++) begin
        expiry_r[k] <= '0;
        reload_r[k] <= '0;
        tfault_r[k] <= '0;
        ttask_r[k]  <= '0;
        tsigs_r[k]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      res_valid_r <= res_valid_nxt;
      scan_r      <= scan_nxt;
      case (state_r)
        potb_pkg::ST_IDLE: begin
          if (in_tvalid) begin
            op_r       <= in_tdata[3:0];
            idx_r      <= in_tdata[11:4];
            pend_r     <= in_tdata[19:12];
            tval_r     <= in_tdata[35:20];
            task_in_r  <= in_tdata[43:36];
            sigs_in_r  <= in_tdata[51:44];
            fault_in_r <= in_tdata[59:52];
            oneshot_r  <= 1'b0;
          end
        end
        potb_pkg::ST_DECODE: begin
          if (op_r == potb_pkg::OP_TICK) begin
            if (pend_r != 8'd0) tick_count_r <= tick_count_r + 1'b1;
          end else if (op_r == potb_pkg::OP_ONESHOT && idx_ok) begin
            reload_r[sel] <= tval_r;
            oneshot_r     <= 1'b1;
          end
        end
        potb_pkg::ST_FIRE: begin
          // Re-arm through the shared adder, or disarm on a zero reload.
          if (reload_r[sel] != 16'd0) expiry_r[sel] <= add_y;
          else armed_r[sel] <= 1'b0;
          if (oneshot_r) reload_r[sel] <= '0;
          if (tfault_r[sel] == 8'd0) begin
            if (outst_r[sel]) overrun_r[sel] <= 1'b1;
            outst_r[sel] <= 1'b1;
          end
        end
        potb_pkg::ST_EMIT: begin
          case (op_r)
            potb_pkg::OP_ENABLE, potb_pkg::OP_ONESHOT: begin
              expiry_r[sel] <= add_y;
              armed_r[sel]  <= 1'b1;
              if (oneshot_r) reload_r[sel] <= '0;
            end
            potb_pkg::OP_DISABLE:  armed_r[sel] <= 1'b0;
            potb_pkg::OP_RELOAD:   reload_r[sel] <= tval_r;
            potb_pkg::OP_OVERFLOW: overrun_r[sel] <= 1'b0;
            potb_pkg::OP_TARGET: begin
              if (sigs_in_r != 8'd0) begin
                tfault_r[sel] <= '0;
                ttask_r[sel]  <= task_in_r;
                tsigs_r[sel]  <= sigs_in_r;
              end
            end
            potb_pkg::OP_FAULT:    tfault_r[sel] <= fault_in_r;
            potb_pkg::OP_CONSUMED: outst_r[sel] <= 1'b0;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the periodic/one-shot timer bank.
`timescale 1ns / 1ps

module tb;

  // One input request as the block sees it.
  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  idx;
    logic [7:0]  pend;
    logic [15:0] tval;
    logic [7:0]  task_id;
    logic [7:0]  sigs;
    logic [7:0]  fault;
  } request_t;

  // One expected result.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  which;
    logic [7:0]  dest;
    logic [7:0]  sigs;
    logic [7:0]  err;
    logic [15:0] reply;
    logic        last;
  } reply_t;

  // A directed row: request plus an optional hand-typed first result.
  typedef struct {
    request_t req;
    bit       typed;
    reply_t   rsp;
  } row_t;

  localparam int MAX_RESULTS = 9;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;

  periodic_oneshot_timer_bank dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow timer state.
  logic [potb_pkg::TICK_BITS-1:0] now_count;
  bit                   t_armed [potb_pkg::NUM_TIMERS];
  bit                   t_overrun [potb_pkg::NUM_TIMERS];
  logic [15:0]          t_expiry [potb_pkg::NUM_TIMERS];
  logic [15:0]          t_reload [potb_pkg::NUM_TIMERS];
  logic [7:0]           t_fault [potb_pkg::NUM_TIMERS];
  logic [7:0]           t_task [potb_pkg::NUM_TIMERS];
  logic [7:0]           t_sigs [potb_pkg::NUM_TIMERS];
  bit                   t_pending [potb_pkg::NUM_TIMERS];

  reply_t pending_results[$];
  reply_t batch[$];
  int     failures = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_off = 1'b0;
  bit     stim_done = 1'b0;

  function automatic reply_t mk(logic [2:0] kind, logic [7:0] which,
                                logic [7:0] dest = 0, logic [7:0] sigs = 0,
                                logic [7:0] err = 0, logic [15:0] reply = 0);
    reply_t r;
    r.kind = kind; r.which = which; r.dest = dest; r.sigs = sigs;
    r.err = err; r.reply = reply; r.last = 1'b0;
    return r;
  endfunction

  function automatic void push(reply_t r);
    if (batch.size() < MAX_RESULTS) batch.push_back(r);
  endfunction

  function automatic void clear_state();
    now_count = '0;
    for (int i = 0; i < potb_pkg::NUM_TIMERS; i++) begin
      t_armed[i] = 0; t_overrun[i] = 0; t_expiry[i] = '0; t_reload[i] = '0;
      t_fault[i] = '0; t_task[i] = '0; t_sigs[i] = '0; t_pending[i] = 0;
    end
  endfunction

  // A timer expires: re-arm or disarm, then report a fault or send signals.
  function automatic void expire(int i);
    if (t_reload[i] != 0) t_expiry[i] = t_expiry[i] + t_reload[i];
    else t_armed[i] = 0;
    if (t_fault[i] != 0) begin
      push(mk(potb_pkg::KIND_FATAL, i[7:0], 0, 0, t_fault[i]));
    end else begin
      if (t_pending[i]) t_overrun[i] = 1;
      t_pending[i] = 1;
      push(mk(potb_pkg::KIND_SIGNAL, i[7:0], t_task[i], t_sigs[i]));
    end
  endfunction

  function automatic void arm_timer(int i);
    if (t_reload[i] == 0) begin
      expire(i);
    end else begin
      t_expiry[i] = now_count[15:0] + t_reload[i];
      t_armed[i] = 1;
      push(mk(potb_pkg::KIND_ACK, i[7:0]));
    end
  endfunction

  // Works out the results of one request and queues them.
  function automatic void predict_timer_bank(request_t q);
    int i;
    batch.delete();
    i = q.idx;
    if (q.op == potb_pkg::OP_TICK) begin
      if (q.pend > 1) push(mk(potb_pkg::KIND_TICK_OVF, 0));
      if (q.pend != 0) begin
        now_count = now_count + 1'b1;
        for (int k = 0; k < potb_pkg::NUM_TIMERS; k++)
          if (t_armed[k] && t_expiry[k] == now_count[15:0]) expire(k);
      end
    end else if (q.op > potb_pkg::OP_CONSUMED) begin
      push(mk(potb_pkg::KIND_ACK, 0));
    end else if (q.idx >= potb_pkg::NUM_TIMERS) begin
      push(mk(potb_pkg::KIND_BAD_ID, q.idx));
    end else begin
      case (potb_pkg::op_t'(q.op))
        potb_pkg::OP_ENABLE: arm_timer(i);
        potb_pkg::OP_DISABLE: begin
          t_armed[i] = 0;
          push(mk(potb_pkg::KIND_ACK, q.idx));
        end
        potb_pkg::OP_ONESHOT: begin
          t_reload[i] = q.tval;
          arm_timer(i);
          t_reload[i] = 0;
        end
        potb_pkg::OP_RELOAD: begin
          t_reload[i] = q.tval;
          push(mk(potb_pkg::KIND_ACK, q.idx));
        end
        potb_pkg::OP_OVERFLOW: begin
          push(mk(potb_pkg::KIND_ACK, q.idx, 0, 0, 0, {15'd0, t_overrun[i]}));
          t_overrun[i] = 0;
        end
        potb_pkg::OP_REMAINING: begin
          push(mk(potb_pkg::KIND_ACK, q.idx, 0, 0, 0,
                  t_armed[i] ? t_expiry[i] - now_count[15:0] : 16'd0));
        end
        potb_pkg::OP_TARGET: begin
          if (q.sigs == 0) begin
            push(mk(potb_pkg::KIND_EMPTY, q.idx));
          end else begin
            t_fault[i] = 0; t_task[i] = q.task_id; t_sigs[i] = q.sigs;
            push(mk(potb_pkg::KIND_ACK, q.idx));
          end
        end
        potb_pkg::OP_FAULT: begin
          t_fault[i] = q.fault;
          push(mk(potb_pkg::KIND_ACK, q.idx));
        end
        default: begin
          t_pending[i] = 0;
          push(mk(potb_pkg::KIND_ACK, q.idx));
        end
      endcase
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) pending_results.push_back(batch[k]);
  endfunction

  function automatic request_t req(logic [3:0] op, logic [7:0] idx,
                                   logic [7:0] pend = 0, logic [15:0] tval = 0,
                                   logic [7:0] task_id = 0, logic [7:0] sigs = 0,
                                   logic [7:0] fault = 0);
    request_t q;
    q.op = op; q.idx = idx; q.pend = pend; q.tval = tval;
    q.task_id = task_id; q.sigs = sigs; q.fault = fault;
    return q;
  endfunction

  // Sends one request, honoring the sender idle rate. Valid stays high on return so
  // that a following request goes out back to back.
  task automatic send(request_t q);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {4'd0, q.fault, q.sigs, q.task_id, q.tval, q.pend, q.idx, q.op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_timer_bank(q);
  endtask

  // Waits at least one edge, then until every expected result has come.
  task automatic drain();
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // Random request: mostly valid timers and ticks, with some noise.
  function automatic request_t rand_req();
    request_t q;
    int r;
    r = $urandom_range(99);
    if (r < 30) q.op = potb_pkg::OP_TICK;
    else if (r < 95) q.op = 4'($urandom_range(potb_pkg::OP_CONSUMED, potb_pkg::OP_ENABLE));
    else q.op = 4'($urandom_range(15, 10));
    q.idx = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                     : 8'($urandom_range(potb_pkg::NUM_TIMERS - 1));
    r = $urandom_range(19);
    q.pend = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom_range(255)) : 8'd1;
    q.tval = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(6));
    q.task_id = 8'($urandom_range(255));
    q.sigs = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255));
    q.fault = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'd0;
    return q;
  endfunction

  // Receiver readiness: random stalls plus one long counted hold-off.
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[2:0] !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_tdata[2:0]); failures++;
        end
        if (out_tdata[10:3] !== e.which) begin
          $error("which_timer: expected %0d, got %0d", e.which, out_tdata[10:3]);
          failures++;
        end
        if (out_tdata[18:11] !== e.dest) begin
          $error("dest_task: expected %0d, got %0d", e.dest, out_tdata[18:11]);
          failures++;
        end
        if (out_tdata[26:19] !== e.sigs) begin
          $error("sent_signals: expected %0d, got %0d", e.sigs, out_tdata[26:19]);
          failures++;
        end
        if (out_tdata[34:27] !== e.err) begin
          $error("error_code: expected %0d, got %0d", e.err, out_tdata[34:27]);
          failures++;
        end
        if (out_tdata[50:35] !== e.reply) begin
          $error("reply_value: expected %0d, got %0d", e.reply, out_tdata[50:35]);
          failures++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_tlast); failures++;
        end
      end
    end
  end

  // Directed table, then random phases.
  initial begin
    row_t rows[$];
    row_t w;
    request_t q;

    clear_state();
    w.typed = 0;
    w.rsp = mk(potb_pkg::KIND_ACK, 0);
    rows.push_back('{req(potb_pkg::OP_REMAINING, 0), 1, mk(potb_pkg::KIND_ACK, 0)});
    rows.push_back('{req(potb_pkg::OP_DISABLE, 8'd255), 1,
                     mk(potb_pkg::KIND_BAD_ID, 8'd255)});
    rows.push_back('{req(4'd15, 8'd3), 1, mk(potb_pkg::KIND_ACK, 0)});
    rows.push_back('{req(4'd10, 8'd0), 1, mk(potb_pkg::KIND_ACK, 0)});
    rows.push_back('{req(potb_pkg::OP_TARGET, 2, 0, 0, 8'd255, 8'd0), 1,
                     mk(potb_pkg::KIND_EMPTY, 2)});
    rows.push_back('{req(potb_pkg::OP_TARGET, 0, 0, 0, 8'd255, 8'd255), 1,
                     mk(potb_pkg::KIND_ACK, 0)});
    rows.push_back('{req(potb_pkg::OP_TARGET, 7, 0, 0, 8'd0, 8'd1), 1,
                     mk(potb_pkg::KIND_ACK, 7)});
    rows.push_back('{req(potb_pkg::OP_TICK, 0, 8'd0), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_TICK, 0, 8'd255), 1, mk(potb_pkg::KIND_TICK_OVF, 0)});
    rows.push_back('{req(potb_pkg::OP_ENABLE, 0), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_ENABLE, 0), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_OVERFLOW, 0), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_CONSUMED, 0), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_FAULT, 7, 0, 0, 0, 0, 8'd255), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_ONESHOT, 7, 0, 16'd0), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_RELOAD, 1, 0, 16'd1), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_ENABLE, 1), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_ONESHOT, 2, 0, 16'hFFFF), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_REMAINING, 2), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_RELOAD, 3, 0, 16'h8000), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_FAULT, 3, 0, 0, 0, 0, 8'h81), 0, w.rsp});
    for (int i = 0; i < potb_pkg::NUM_TIMERS; i++)
      rows.push_back('{req(potb_pkg::OP_ONESHOT, i[7:0], 0, 16'd1), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_TICK, 0, 8'd1), 0, w.rsp});
    rows.push_back('{req(potb_pkg::OP_TICK, 0, 8'd2), 0, w.rsp});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; typed rows cross-check the first predicted result.
    foreach (rows[k]) begin
      send(rows[k].req);
      if (rows[k].typed) begin
        w.rsp = rows[k].rsp;
        w.rsp.last = 1'b1;
        if (batch.size() == 0 || batch[0] != w.rsp) begin
          $error("typed row %0d disagrees with prediction", k);
          failures++;
        end
      end
    end
    in_tvalid <= 1'b0;
    drain();

    // Random phases with different idling.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 74 : 9) : 0;
      recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 9 : 0;
      for (int k = 0; k < 70; k++) send(rand_req());
      in_tvalid <= 1'b0;
      drain();
    end

    // Long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int k = 0; k < 20; k++) begin
          q = rand_req();
          send(q);
        end
        in_tvalid <= 1'b0;
      end
    join
    drain();
    stim_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stim_done);
    repeat (40) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("PASS periodic_oneshot_timer_bank");
    end else begin
      $display("FAIL periodic_oneshot_timer_bank");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL periodic_oneshot_timer_bank");
    $finish;
  end

endmodule

// ===== periodic_oneshot_timer_bank.f =====
sv/potb_pkg.sv
sv/periodic_oneshot_timer_bank.sv
verif/tb.sv
